/* sv/cap_pkg.sv */
// shared types, constants, microcode program and helpers for the cascaded angle/rate pid
package cap_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_OUTER_KP    = 3'd0;
    localparam logic [2:0] CFG_OUTER_KI    = 3'd1;
    localparam logic [2:0] CFG_OUTER_KD    = 3'd2;
    localparam logic [2:0] CFG_INNER_KP    = 3'd3;
    localparam logic [2:0] CFG_INNER_KI    = 3'd4;
    localparam logic [2:0] CFG_INNER_KD    = 3'd5;
    localparam logic [2:0] CFG_TICK_PERIOD = 3'd6;
    localparam logic [2:0] CFG_TICK_RATE   = 3'd7;

    localparam logic [16:0] TICK_PERIOD_RST = 17'd262;
    localparam logic [31:0] TICK_RATE_RST   = 32'd16384000;

    // fixed-point constants
    localparam logic signed [12:0] RC_CENTRE      = 13'sd1500;
    localparam logic signed [31:0] Q_ONE_TENTH    = 32'sd6554;
    localparam logic [31:0]        IIR_OLD_W      = 32'd19661;
    localparam logic [31:0]        IIR_NEW_W      = 32'd45875;
    localparam logic signed [32:0] INTEGRAL_LIMIT = 33'sd32768000;
    localparam logic signed [64:0] ROUND_HALF     = 65'sd32768;

    // micro-operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_JNC      = 4'd1;  // jump when clear flag is low
    localparam logic [3:0] OP_CLR      = 4'd2;
    localparam logic [3:0] OP_SUBS     = 4'd3;  // saturating a - b
    localparam logic [3:0] OP_MUL      = 4'd4;  // product register = a * gain
    localparam logic [3:0] OP_HOLD     = 4'd5;  // accumulator = product register
    localparam logic [3:0] OP_RND      = 4'd6;  // round and saturate the product
    localparam logic [3:0] OP_RNDA     = 4'd7;  // round and saturate product + accumulator
    localparam logic [3:0] OP_ADDCLAMP = 4'd8;  // integral add with +-500 clamp
    localparam logic [3:0] OP_MOV      = 4'd9;
    localparam logic [3:0] OP_HADD     = 4'd10; // floor((a + b + 1) / 2)
    localparam logic [3:0] OP_WADD     = 4'd11; // wide sum register = a + b
    localparam logic [3:0] OP_WSUBS    = 4'd12; // saturating wide sum - b

    // register file slots
    localparam int unsigned RF_DEPTH = 16;
    localparam logic [3:0] RF_OINT  = 4'd0;
    localparam logic [3:0] RF_OFILT = 4'd1;
    localparam logic [3:0] RF_IINT  = 4'd2;
    localparam logic [3:0] RF_IFILT = 4'd3;
    localparam logic [3:0] RF_PREV  = 4'd4;
    localparam logic [3:0] RF_ERR   = 4'd5;
    localparam logic [3:0] RF_P     = 4'd6;
    localparam logic [3:0] RF_I     = 4'd7;
    localparam logic [3:0] RF_D     = 4'd8;
    localparam logic [3:0] RF_T     = 4'd9;

    // operand sources: top bit set selects a non-file source
    localparam logic [4:0] SRC_OINT  = {1'b0, RF_OINT};
    localparam logic [4:0] SRC_OFILT = {1'b0, RF_OFILT};
    localparam logic [4:0] SRC_IINT  = {1'b0, RF_IINT};
    localparam logic [4:0] SRC_IFILT = {1'b0, RF_IFILT};
    localparam logic [4:0] SRC_PREV  = {1'b0, RF_PREV};
    localparam logic [4:0] SRC_ERR   = {1'b0, RF_ERR};
    localparam logic [4:0] SRC_P     = {1'b0, RF_P};
    localparam logic [4:0] SRC_I     = {1'b0, RF_I};
    localparam logic [4:0] SRC_D     = {1'b0, RF_D};
    localparam logic [4:0] SRC_T     = {1'b0, RF_T};
    localparam logic [4:0] SRC_GYRO  = 5'd16;
    localparam logic [4:0] SRC_ANGLE = 5'd17;
    localparam logic [4:0] SRC_SP    = 5'd18;
    localparam logic [4:0] SRC_RSP   = 5'd19;

    // gain selects for the multiplier
    localparam logic [3:0] G_OKP  = 4'd0;
    localparam logic [3:0] G_OKI  = 4'd1;
    localparam logic [3:0] G_OKD  = 4'd2;
    localparam logic [3:0] G_IKP  = 4'd3;
    localparam logic [3:0] G_IKI  = 4'd4;
    localparam logic [3:0] G_IKD  = 4'd5;
    localparam logic [3:0] G_PER  = 4'd6;
    localparam logic [3:0] G_RATE = 4'd7;
    localparam logic [3:0] G_WOLD = 4'd8;
    localparam logic [3:0] G_WNEW = 4'd9;

    localparam int unsigned   STEP_W     = 6;
    localparam logic [5:0]    PROG_LEN   = 6'd36;
    localparam logic [5:0]    STEP_OUTER = 6'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] dst;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [3:0] gsel;
        logic       ld_rsp;
        logic       last;
        logic [5:0] target;
    } cap_cw_t;

    typedef struct packed {
        cap_cw_t cw;
        logic    fetch;
        logic    exec;
    } cap_ctl_t;

    typedef struct packed {
        logic [31:0] outer_kp;
        logic [31:0] outer_ki;
        logic [31:0] outer_kd;
        logic [31:0] inner_kp;
        logic [31:0] inner_ki;
        logic [31:0] inner_kd;
        logic [16:0] tick_period;
        logic [31:0] tick_rate;
    } cap_gains_t;

    typedef struct packed {
        logic signed [31:0] gyro;
        logic signed [31:0] angle;
        logic signed [31:0] sp;
    } cap_inputs_t;

    function automatic logic signed [31:0] cap_sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic cap_cw_t mk(input logic [3:0] op, input logic [3:0] dst,
                                   input logic [4:0] a, input logic [4:0] b,
                                   input logic [3:0] g, input logic ldr,
                                   input logic lst, input logic [5:0] tgt);
        cap_cw_t w;
        w.op     = op;
        w.dst    = dst;
        w.src_a  = a;
        w.src_b  = b;
        w.gsel   = g;
        w.ld_rsp = ldr;
        w.last   = lst;
        w.target = tgt;
        return w;
    endfunction

    // control store: one word per step
    function automatic cap_cw_t cap_ucode(input logic [5:0] step);
        cap_cw_t w;
        case (step)
            // optional integrator clear
            6'd0:  w = mk(OP_JNC,      RF_T,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, STEP_OUTER);
            6'd1:  w = mk(OP_CLR,      RF_OINT,  SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd2:  w = mk(OP_CLR,      RF_IINT,  SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            // outer angle loop
            6'd3:  w = mk(OP_SUBS,     RF_ERR,   SRC_SP,    SRC_ANGLE, G_OKP, 1'b0, 1'b0, 6'd0);
            6'd4:  w = mk(OP_MUL,      RF_T,     SRC_ERR,   SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd5:  w = mk(OP_RND,      RF_P,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd6:  w = mk(OP_MUL,      RF_T,     SRC_ERR,   SRC_T,   G_PER,  1'b0, 1'b0, 6'd0);
            6'd7:  w = mk(OP_RND,      RF_T,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd8:  w = mk(OP_ADDCLAMP, RF_OINT,  SRC_OINT,  SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd9:  w = mk(OP_MUL,      RF_T,     SRC_OINT,  SRC_T,   G_OKI,  1'b0, 1'b0, 6'd0);
            6'd10: w = mk(OP_RND,      RF_I,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd11: w = mk(OP_MUL,      RF_T,     SRC_OFILT, SRC_T,   G_WOLD, 1'b0, 1'b0, 6'd0);
            6'd12: w = mk(OP_HOLD,     RF_T,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd13: w = mk(OP_MUL,      RF_T,     SRC_GYRO,  SRC_T,   G_WNEW, 1'b0, 1'b0, 6'd0);
            6'd14: w = mk(OP_RNDA,     RF_OFILT, SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd15: w = mk(OP_MUL,      RF_T,     SRC_OFILT, SRC_T,   G_OKD,  1'b0, 1'b0, 6'd0);
            6'd16: w = mk(OP_RND,      RF_D,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd17: w = mk(OP_WADD,     RF_T,     SRC_P,     SRC_I,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd18: w = mk(OP_WSUBS,    RF_T,     SRC_T,     SRC_D,   G_OKP,  1'b1, 1'b0, 6'd0);
            // inner rate loop
            6'd19: w = mk(OP_SUBS,     RF_ERR,   SRC_RSP,   SRC_GYRO, G_OKP, 1'b0, 1'b0, 6'd0);
            6'd20: w = mk(OP_MUL,      RF_T,     SRC_ERR,   SRC_T,   G_IKP,  1'b0, 1'b0, 6'd0);
            6'd21: w = mk(OP_RND,      RF_P,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd22: w = mk(OP_MUL,      RF_T,     SRC_ERR,   SRC_T,   G_PER,  1'b0, 1'b0, 6'd0);
            6'd23: w = mk(OP_RND,      RF_T,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd24: w = mk(OP_ADDCLAMP, RF_IINT,  SRC_IINT,  SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd25: w = mk(OP_MUL,      RF_T,     SRC_IINT,  SRC_T,   G_IKI,  1'b0, 1'b0, 6'd0);
            6'd26: w = mk(OP_RND,      RF_I,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd27: w = mk(OP_SUBS,     RF_T,     SRC_GYRO,  SRC_PREV, G_OKP, 1'b0, 1'b0, 6'd0);
            6'd28: w = mk(OP_MUL,      RF_T,     SRC_T,     SRC_T,   G_RATE, 1'b0, 1'b0, 6'd0);
            6'd29: w = mk(OP_RND,      RF_T,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd30: w = mk(OP_MOV,      RF_PREV,  SRC_GYRO,  SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd31: w = mk(OP_HADD,     RF_IFILT, SRC_IFILT, SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd32: w = mk(OP_MUL,      RF_T,     SRC_IFILT, SRC_T,   G_IKD,  1'b0, 1'b0, 6'd0);
            6'd33: w = mk(OP_RND,      RF_D,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd34: w = mk(OP_WADD,     RF_T,     SRC_P,     SRC_I,   G_OKP,  1'b0, 1'b0, 6'd0);
            6'd35: w = mk(OP_WSUBS,    RF_T,     SRC_T,     SRC_D,   G_OKP,  1'b0, 1'b1, 6'd0);
            default: w = mk(OP_NOP,    RF_T,     SRC_T,     SRC_T,   G_OKP,  1'b0, 1'b1, 6'd0);
        endcase
        return w;
    endfunction

endpackage

/* sv/cap_sequencer.sv */
// step counter, control store lookup and two-phase fetch/execute control
module cap_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              clear_flag,
    input  logic              out_free,
    output logic              busy,
    output logic              done,
    output cap_pkg::cap_ctl_t ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [cap_pkg::STEP_W-1:0]   step_reg, step_next;
    cap_pkg::cap_cw_t             cw;
    logic                         stall;

    assign cw    = cap_pkg::cap_ucode(step_reg);
    assign stall = cw.last && !out_free;

    // phase control and step advance
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        done       = 1'b0;
        ctl.cw     = cw;
        ctl.fetch  = 1'b0;
        ctl.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_FETCH;
                    step_next  = '0;
                end
            end
            ST_FETCH: begin
                ctl.fetch  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!stall) begin
                    ctl.exec = 1'b1;
                    if (cw.last) begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_FETCH;
                        if (cw.op == cap_pkg::OP_JNC && !clear_flag) begin
                            step_next = cw.target;
                        end else begin
                            step_next = step_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    a_step_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> step_reg < cap_pkg::PROG_LEN)
        else $error("step counter left the program");

    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (ctl.exec && cw.last && state_reg == ST_EXEC))
        else $error("done without executing the last step");

    a_start_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_FETCH && step_reg == '0))
        else $error("program did not start at step zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && stall) |=> (state_reg == ST_EXEC && $stable(step_reg)))
        else $error("last step moved while the output was full");

endmodule

/* sv/cap_datapath.sv */
// register file, shared multiplier and saturating alu driven by the control word
module cap_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cap_pkg::cap_ctl_t         ctl,
    input  cap_pkg::cap_gains_t       gains,
    input  cap_pkg::cap_inputs_t      ins,
    output logic signed [31:0]        result,
    output logic signed [31:0]        rsp
);

    logic signed [31:0]             rf_mem [cap_pkg::RF_DEPTH];
    logic [cap_pkg::RF_DEPTH-1:0]   rf_valid_reg;

    logic signed [31:0] opa_reg, opb_reg;
    logic signed [31:0] ext_a, ext_b;
    logic signed [63:0] prod_reg, acc_reg;
    logic signed [32:0] w_reg;
    logic signed [31:0] rsp_reg;

    logic [31:0]        gain;
    logic signed [32:0] opa33, g33;
    logic signed [64:0] mul_full;
    logic signed [32:0] sum33, diff33, clamp33;
    logic signed [33:0] half34, wdiff34;
    logic signed [64:0] rnd_sum, rnd_sh;
    logic               wr_en;

    // non-file operand sources
    always_comb begin
        unique case (ctl.cw.src_a)
            cap_pkg::SRC_GYRO:  ext_a = ins.gyro;
            cap_pkg::SRC_ANGLE: ext_a = ins.angle;
            cap_pkg::SRC_SP:    ext_a = ins.sp;
            cap_pkg::SRC_RSP:   ext_a = rsp_reg;
            default:            ext_a = '0;
        endcase
        unique case (ctl.cw.src_b)
            cap_pkg::SRC_GYRO:  ext_b = ins.gyro;
            cap_pkg::SRC_ANGLE: ext_b = ins.angle;
            cap_pkg::SRC_SP:    ext_b = ins.sp;
            cap_pkg::SRC_RSP:   ext_b = rsp_reg;
            default:            ext_b = '0;
        endcase
    end

    // operand fetch with registered file read; unwritten state reads as zero
    always_ff @(posedge aclk) begin
        if (ctl.fetch) begin
            if (ctl.cw.src_a[4]) begin
                opa_reg <= ext_a;
            end else if (rf_valid_reg[ctl.cw.src_a[3:0]]) begin
                opa_reg <= rf_mem[ctl.cw.src_a[3:0]];
            end else begin
                opa_reg <= '0;
            end
            if (ctl.cw.src_b[4]) begin
                opb_reg <= ext_b;
            end else if (rf_valid_reg[ctl.cw.src_b[3:0]]) begin
                opb_reg <= rf_mem[ctl.cw.src_b[3:0]];
            end else begin
                opb_reg <= '0;
            end
        end
    end

    // gain select
    always_comb begin
        unique case (ctl.cw.gsel)
            cap_pkg::G_OKP:  gain = gains.outer_kp;
            cap_pkg::G_OKI:  gain = gains.outer_ki;
            cap_pkg::G_OKD:  gain = gains.outer_kd;
            cap_pkg::G_IKP:  gain = gains.inner_kp;
            cap_pkg::G_IKI:  gain = gains.inner_ki;
            cap_pkg::G_IKD:  gain = gains.inner_kd;
            cap_pkg::G_PER:  gain = 32'(gains.tick_period);
            cap_pkg::G_RATE: gain = gains.tick_rate;
            cap_pkg::G_WOLD: gain = cap_pkg::IIR_OLD_W;
            cap_pkg::G_WNEW: gain = cap_pkg::IIR_NEW_W;
            default:         gain = '0;
        endcase
    end

    // signed value times unsigned gain
    assign opa33    = 33'(opa_reg);
    assign g33      = $signed({1'b0, gain});
    assign mul_full = opa33 * g33;

    // alu paths
    assign sum33   = 33'(opa_reg) + 33'(opb_reg);
    assign diff33  = 33'(opa_reg) - 33'(opb_reg);
    assign half34  = (34'(opa_reg) + 34'(opb_reg) + 34'sd1) >>> 1;
    assign wdiff34 = 34'(w_reg) - 34'(opb_reg);
    assign rnd_sum = 65'(prod_reg)
                   + ((ctl.cw.op == cap_pkg::OP_RNDA) ? 65'(acc_reg) : 65'sd0)
                   + cap_pkg::ROUND_HALF;
    assign rnd_sh  = rnd_sum >>> 16;

    always_comb begin
        if (sum33 > cap_pkg::INTEGRAL_LIMIT) begin
            clamp33 = cap_pkg::INTEGRAL_LIMIT;
        end else if (sum33 < -cap_pkg::INTEGRAL_LIMIT) begin
            clamp33 = -cap_pkg::INTEGRAL_LIMIT;
        end else begin
            clamp33 = sum33;
        end
    end

    // result select
    always_comb begin
        result = '0;
        wr_en  = 1'b0;
        unique case (ctl.cw.op) inside
            cap_pkg::OP_CLR: begin
                wr_en = 1'b1;
            end
            cap_pkg::OP_SUBS: begin
                result = cap_pkg::cap_sat32(66'(diff33));
                wr_en  = 1'b1;
            end
            cap_pkg::OP_RND, cap_pkg::OP_RNDA: begin
                result = cap_pkg::cap_sat32(66'(rnd_sh));
                wr_en  = 1'b1;
            end
            cap_pkg::OP_ADDCLAMP: begin
                result = clamp33[31:0];
                wr_en  = 1'b1;
            end
            cap_pkg::OP_MOV: begin
                result = opa_reg;
                wr_en  = 1'b1;
            end
            cap_pkg::OP_HADD: begin
                result = half34[31:0];
                wr_en  = 1'b1;
            end
            cap_pkg::OP_WSUBS: begin
                result = cap_pkg::cap_sat32(66'(wdiff34));
                wr_en  = 1'b1;
            end
            default: begin
                result = '0;
                wr_en  = 1'b0;
            end
        endcase
    end

    // register file write
    always_ff @(posedge aclk) begin
        if (ctl.exec && wr_en) begin
            rf_mem[ctl.cw.dst] <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (ctl.exec && wr_en) begin
            rf_valid_reg[ctl.cw.dst] <= 1'b1;
        end
    end

    // product, accumulator, wide sum and rate setpoint registers
    always_ff @(posedge aclk) begin
        if (ctl.exec) begin
            if (ctl.cw.op == cap_pkg::OP_MUL) begin
                prod_reg <= mul_full[63:0];
            end
            if (ctl.cw.op == cap_pkg::OP_HOLD) begin
                acc_reg <= prod_reg;
            end
            if (ctl.cw.op == cap_pkg::OP_WADD) begin
                w_reg <= sum33;
            end
            if (ctl.cw.ld_rsp) begin
                rsp_reg <= result;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

/* sv/cascaded_angle_rate_pid.sv */
// top level: configuration registers, input capture, output register and the sequenced core
//
//  channel   direction  transfer condition        payload
//  s_*       in         s_valid && s_ready        rc_pulse, gyro_rate, attitude_angle, clear
//  m_*       out        m_valid && m_ready        rate_cmd, drive
//  cfg_*     in         cfg_we                    cfg_index selects register, cfg_data
//
//  each item runs 34 microprogram steps, 36 when the clear flag is set, each step
//  an operand fetch phase and then an execute phase, from input transfer up to m_valid.
//  s_ready rises in the same cycle as m_valid, so items are taken one at a time.
//  the single shared multiplier and the fetch/execute split of every step set the pace.
//  s_ready is high whenever no program is running; the last step holds while m_* is still full.
//  synchronous active-low reset returns control state, registers and all loop state to defaults.
module cascaded_angle_rate_pid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_rc_pulse,
    input  logic signed [31:0] s_gyro_rate,
    input  logic signed [31:0] s_attitude_angle,
    input  logic               s_clear_integrals,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_rate_cmd,
    output logic signed [31:0] m_drive,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cap_pkg::cap_gains_t   gains_reg;
    cap_pkg::cap_inputs_t  ins_reg;
    logic                  clear_reg;
    logic                  m_valid_reg;
    logic signed [31:0]    m_rate_cmd_reg, m_drive_reg;

    logic                  start, busy, done, out_free;
    cap_pkg::cap_ctl_t     ctl;
    logic signed [31:0]    result, rsp;
    logic signed [12:0]    pulse_offset;
    logic signed [31:0]    sp_next;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.outer_kp    <= '0;
            gains_reg.outer_ki    <= '0;
            gains_reg.outer_kd    <= '0;
            gains_reg.inner_kp    <= '0;
            gains_reg.inner_ki    <= '0;
            gains_reg.inner_kd    <= '0;
            gains_reg.tick_period <= cap_pkg::TICK_PERIOD_RST;
            gains_reg.tick_rate   <= cap_pkg::TICK_RATE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cap_pkg::CFG_OUTER_KP:    gains_reg.outer_kp    <= cfg_data;
                cap_pkg::CFG_OUTER_KI:    gains_reg.outer_ki    <= cfg_data;
                cap_pkg::CFG_OUTER_KD:    gains_reg.outer_kd    <= cfg_data;
                cap_pkg::CFG_INNER_KP:    gains_reg.inner_kp    <= cfg_data;
                cap_pkg::CFG_INNER_KI:    gains_reg.inner_ki    <= cfg_data;
                cap_pkg::CFG_INNER_KD:    gains_reg.inner_kd    <= cfg_data;
                cap_pkg::CFG_TICK_PERIOD: gains_reg.tick_period <= cfg_data[16:0];
                cap_pkg::CFG_TICK_RATE:   gains_reg.tick_rate   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input capture; angle setpoint is (pulse - 1500) * 0.1 in q16.16
    assign s_ready      = !busy;
    assign start        = s_valid && s_ready;
    assign pulse_offset = $signed({1'b0, s_rc_pulse}) - cap_pkg::RC_CENTRE;
    assign sp_next      = 32'(pulse_offset) * cap_pkg::Q_ONE_TENTH;

    always_ff @(posedge aclk) begin
        if (start) begin
            ins_reg.gyro  <= s_gyro_rate;
            ins_reg.angle <= s_attitude_angle;
            ins_reg.sp    <= sp_next;
            clear_reg     <= s_clear_integrals;
        end
    end

    cap_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .clear_flag (clear_reg),
        .out_free   (out_free),
        .busy       (busy),
        .done       (done),
        .ctl        (ctl)
    );

    cap_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .gains   (gains_reg),
        .ins     (ins_reg),
        .result  (result),
        .rsp     (rsp)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_rate_cmd_reg <= rsp;
            m_drive_reg    <= result;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_rate_cmd = m_rate_cmd_reg;
    assign m_drive    = m_drive_reg;

endmodule

/* tb/testbench.sv */
// self-checking testbench for the cascaded angle/rate pid with a built-in predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // one control tick as presented on s_*
    typedef struct packed {
        logic [11:0] rc_pulse;
        logic [31:0] gyro_rate;
        logic [31:0] attitude_angle;
        logic        clear_integrals;
    } tick_in_t;

    // one result as seen on m_*
    typedef struct packed {
        logic [31:0] rate_cmd;
        logic [31:0] drive;
    } tick_out_t;

    localparam longint PULSE_MID   = 64'sd1500;
    localparam longint TENTH_Q16   = 64'sd6554;
    localparam longint LAG_OLD     = 64'sd19661;
    localparam longint LAG_NEW     = 64'sd45875;
    localparam longint WINDUP_MAX  = 64'sd32768000;
    localparam longint HALF_LSB    = 64'sd32768;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = 64'shffffffff80000000;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [11:0]        s_rc_pulse = '0;
    logic signed [31:0] s_gyro_rate = '0;
    logic signed [31:0] s_attitude_angle = '0;
    logic               s_clear_integrals = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_rate_cmd;
    logic signed [31:0] m_drive;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // predictor copy of the configuration
    longint gain_okp = 0, gain_oki = 0, gain_okd = 0;
    longint gain_ikp = 0, gain_iki = 0, gain_ikd = 0;
    longint period_q16 = 262, rate_q16 = 64'sd16384000;

    // predictor copy of the loop state
    longint angle_integ = 0, angle_dfilt = 0;
    longint rate_integ = 0, rate_dfilt = 0, last_gyro = 0;

    tick_in_t  tick_backlog[$];
    tick_out_t predicted[$];
    logic [31:0] cfg_plan [8];

    int mismatches = 0;
    int ticks_accepted = 0;
    int results_seen = 0;

    cascaded_angle_rate_pid dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rc_pulse        (s_rc_pulse),
        .s_gyro_rate       (s_gyro_rate),
        .s_attitude_angle  (s_attitude_angle),
        .s_clear_integrals (s_clear_integrals),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rate_cmd        (m_rate_cmd),
        .m_drive           (m_drive),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #4 aclk = ~aclk;

    // saturate to the signed 32-bit range
    function automatic longint clip32(input longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    // q16.16 value times unsigned gain, round half up, saturate
    function automatic longint gain_mul(input longint a, input longint g);
        return clip32((a * g + HALF_LSB) >>> 16);
    endfunction

    function automatic longint windup_clip(input longint v);
        if (v > WINDUP_MAX) begin
            return WINDUP_MAX;
        end
        if (v < -WINDUP_MAX) begin
            return -WINDUP_MAX;
        end
        return v;
    endfunction

    // both loops for one tick, advancing the predictor state
    function automatic tick_out_t pid_tick(input tick_in_t t);
        longint gyro, angle, sp, err, p, i, d, rsp, rerr, dgy, deriv, drv;
        tick_out_t r;
        gyro  = $signed(t.gyro_rate);
        angle = $signed(t.attitude_angle);
        if (t.clear_integrals) begin
            angle_integ = 0;
            rate_integ  = 0;
        end
        // angle loop
        sp  = (longint'(t.rc_pulse) - PULSE_MID) * TENTH_Q16;
        err = clip32(sp - angle);
        p   = gain_mul(err, gain_okp);
        angle_integ = windup_clip(angle_integ + gain_mul(err, period_q16));
        i   = gain_mul(angle_integ, gain_oki);
        angle_dfilt = clip32((angle_dfilt * LAG_OLD + gyro * LAG_NEW + HALF_LSB) >>> 16);
        d   = gain_mul(angle_dfilt, gain_okd);
        rsp = clip32(p + i - d);
        // rate loop
        rerr  = clip32(rsp - gyro);
        p     = gain_mul(rerr, gain_ikp);
        rate_integ = windup_clip(rate_integ + gain_mul(rerr, period_q16));
        i     = gain_mul(rate_integ, gain_iki);
        dgy   = clip32(gyro - last_gyro);
        deriv = gain_mul(dgy, rate_q16);
        last_gyro = gyro;
        rate_dfilt = clip32((rate_dfilt + deriv + 64'sd1) >>> 1);
        d     = gain_mul(rate_dfilt, gain_ikd);
        drv   = clip32(p + i - d);
        r.rate_cmd = rsp[31:0];
        r.drive    = drv[31:0];
        return r;
    endfunction

    function automatic void shadow_write(input logic [2:0] idx, input logic [31:0] v);
        case (idx)
            cap_pkg::CFG_OUTER_KP:    gain_okp   = longint'(v);
            cap_pkg::CFG_OUTER_KI:    gain_oki   = longint'(v);
            cap_pkg::CFG_OUTER_KD:    gain_okd   = longint'(v);
            cap_pkg::CFG_INNER_KP:    gain_ikp   = longint'(v);
            cap_pkg::CFG_INNER_KI:    gain_iki   = longint'(v);
            cap_pkg::CFG_INNER_KD:    gain_ikd   = longint'(v);
            cap_pkg::CFG_TICK_PERIOD: period_q16 = longint'(v[16:0]);
            cap_pkg::CFG_TICK_RATE:   rate_q16   = longint'(v);
            default: ;
        endcase
    endfunction

    // random tick: mostly plausible flight values, the rest random or at the extremes
    function automatic tick_in_t rand_tick();
        tick_in_t t;
        int g, a;
        g = int'($urandom_range(0, 26214400)) - 13107200;
        a = int'($urandom_range(0, 11796480)) - 5898240;
        t.rc_pulse        = 12'($urandom_range(900, 2100));
        t.gyro_rate       = g;
        t.attitude_angle  = a;
        t.clear_integrals = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 9))
            7: begin
                t.rc_pulse       = 12'($urandom);
                t.gyro_rate      = $urandom;
                t.attitude_angle = $urandom;
            end
            8: begin
                t.gyro_rate      = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
                t.attitude_angle = $urandom;
            end
            9: begin
                t.rc_pulse       = $urandom_range(0, 1) ? 12'hfff : 12'h000;
                t.attitude_angle = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic add_tick(input logic [11:0] p, input logic [31:0] g,
                            input logic [31:0] a, input logic c);
        tick_in_t t;
        t.rc_pulse        = p;
        t.gyro_rate       = g;
        t.attitude_angle  = a;
        t.clear_integrals = c;
        tick_backlog.push_back(t);
    endtask

    task automatic add_random(input int n);
        for (int k = 0; k < n; k++) begin
            tick_backlog.push_back(rand_tick());
        end
    endtask

    // write the enabled entries of cfg_plan, one per cycle
    task automatic apply_config(input logic [7:0] en);
        for (int k = 0; k < 8; k++) begin
            if (en[k]) begin
                @(posedge aclk);
                cfg_we    <= 1'b1;
                cfg_index <= 3'(k);
                cfg_data  <= cfg_plan[k];
                shadow_write(3'(k), cfg_plan[k]);
            end
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // checked between edges so the sender and receiver have settled
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (tick_backlog.size() != 0 || s_valid || predicted.size() != 0);
    endtask

    // sender: bursts and gaps, occasional pause until the pipeline drains
    int  gap_left = 0;
    int  burst_left = 0;
    logic draining = 1'b0;
    tick_in_t on_bus;

    always @(posedge aclk) begin : sender
        logic offer;
        if (aresetn) begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                predicted.push_back(pid_tick(on_bus));
                ticks_accepted++;
                offer = 1'b0;
                if (ticks_accepted % 300 == 120) begin
                    draining = 1'b1;
                end
            end
            if (draining && predicted.size() == 0) begin
                draining = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!draining && tick_backlog.size() != 0) begin
                    on_bus = tick_backlog.pop_front();
                    offer  = 1'b1;
                    s_rc_pulse        <= on_bus.rc_pulse;
                    s_gyro_rate       <= on_bus.gyro_rate;
                    s_attitude_angle  <= on_bus.attitude_angle;
                    s_clear_integrals <= on_bus.clear_integrals;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 4))
                            0, 1: gap_left = 0;
                            2, 3: gap_left = $urandom_range(1, 8);
                            default: gap_left = $urandom_range(9, 40);
                        endcase
                    end
                end
            end
            s_valid <= offer;
        end
    end

    // receiver: checks each result transfer and stalls on its own pattern
    int stall_left = 0;
    int hold_left = 0;
    int rx_mode = 0;

    always @(posedge aclk) begin : receiver
        tick_out_t want;
        logic rdy;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted.size() == 0) begin
                    $display("%0t: result with none pending: rate_cmd=%h drive=%h",
                             $time, m_rate_cmd, m_drive);
                    mismatches++;
                end else begin
                    want = predicted.pop_front();
                    if (m_rate_cmd !== want.rate_cmd) begin
                        $display("%0t: rate_cmd expected %h actual %h",
                                 $time, want.rate_cmd, m_rate_cmd);
                        mismatches++;
                    end
                    if (m_drive !== want.drive) begin
                        $display("%0t: drive expected %h actual %h",
                                 $time, want.drive, m_drive);
                        mismatches++;
                    end
                end
                results_seen++;
                if (results_seen % 64 == 0) begin
                    rx_mode = $urandom_range(0, 3);
                end
                // long hold so the block backs up and stalls its input
                if (results_seen == 150 || results_seen == 550) begin
                    hold_left = 600;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                case (rx_mode)
                    1: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 4);
                    2: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 30);
                    3: stall_left = $urandom_range(0, 90);
                    default: ;
                endcase
            end
            m_ready <= rdy;
        end
    end

    // phases of configuration and stimulus
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: gains zero, integrators still run
        add_random(10);
        wait_idle();

        // directed ticks with moderate gains and reset period and rate
        cfg_plan[cap_pkg::CFG_OUTER_KP] = 32'd131072;
        cfg_plan[cap_pkg::CFG_OUTER_KI] = 32'd32768;
        cfg_plan[cap_pkg::CFG_OUTER_KD] = 32'd16384;
        cfg_plan[cap_pkg::CFG_INNER_KP] = 32'd98304;
        cfg_plan[cap_pkg::CFG_INNER_KI] = 32'd16384;
        cfg_plan[cap_pkg::CFG_INNER_KD] = 32'd655;
        apply_config(8'h3f);
        add_tick(12'd1500, 32'd0, 32'd0, 1'b0);
        add_tick(12'd0, 32'd0, 32'd0, 1'b0);
        add_tick(12'hfff, 32'd0, 32'd0, 1'b0);
        add_tick(12'd1500, 32'd0, 32'h7fff_ffff, 1'b0);
        add_tick(12'd1500, 32'd0, 32'h8000_0000, 1'b0);
        add_tick(12'd0, 32'd0, 32'h7fff_ffff, 1'b0);
        add_tick(12'hfff, 32'd0, 32'h8000_0000, 1'b0);
        // huge gyro steps in both directions
        add_tick(12'd1500, 32'h7fff_ffff, 32'd0, 1'b0);
        add_tick(12'd1500, 32'h8000_0000, 32'd0, 1'b0);
        add_tick(12'd1500, 32'h7fff_ffff, 32'd0, 1'b0);
        add_tick(12'd1500, 32'd0, 32'd0, 1'b0);
        add_tick(12'd2000, 32'd0, 32'd0, 1'b1);
        // drive both integrators into their clamps, then the other way
        for (int k = 0; k < 5; k++) begin
            add_tick(12'hfff, 32'd0, 32'h8000_0000, 1'b0);
        end
        for (int k = 0; k < 5; k++) begin
            add_tick(12'd0, 32'd0, 32'h7fff_ffff, 1'b0);
        end
        add_tick(12'd1000, 32'd6553600, 32'd655360, 1'b1);
        add_tick(12'd1600, 32'hff9c_0000, 32'hfff6_0000, 1'b0);
        wait_idle();

        // moderate random gains and timing
        for (int k = 0; k < 6; k++) begin
            cfg_plan[k] = $urandom_range(0, 4 * Q_ONE);
        end
        cfg_plan[cap_pkg::CFG_TICK_PERIOD] = $urandom_range(1, 2000);
        cfg_plan[cap_pkg::CFG_TICK_RATE]   = $urandom_range(1, 32'd67108864);
        apply_config(8'hff);
        add_random(250);
        wait_idle();

        // every gain and the rate at its top value, the period at 65536
        for (int k = 0; k < 6; k++) begin
            cfg_plan[k] = 32'hffff_ffff;
        end
        cfg_plan[cap_pkg::CFG_TICK_PERIOD] = 32'd65536;
        cfg_plan[cap_pkg::CFG_TICK_RATE]   = 32'hffff_ffff;
        apply_config(8'hff);
        add_random(150);
        wait_idle();

        // zero period and zero rate: integrators frozen, rate derivative gone
        for (int k = 0; k < 6; k++) begin
            cfg_plan[k] = $urandom;
        end
        cfg_plan[cap_pkg::CFG_TICK_PERIOD] = 32'd0;
        cfg_plan[cap_pkg::CFG_TICK_RATE]   = 32'd0;
        apply_config(8'hff);
        add_random(100);
        wait_idle();

        // smallest nonzero period and rate
        for (int k = 0; k < 6; k++) begin
            cfg_plan[k] = $urandom_range(0, 16 * Q_ONE);
        end
        cfg_plan[cap_pkg::CFG_TICK_PERIOD] = 32'd1;
        cfg_plan[cap_pkg::CFG_TICK_RATE]   = 32'd1;
        apply_config(8'hff);
        add_random(150);
        wait_idle();

        // anything goes
        for (int k = 0; k < 6; k++) begin
            cfg_plan[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * Q_ONE);
        end
        cfg_plan[cap_pkg::CFG_TICK_PERIOD] = $urandom_range(0, 65536);
        cfg_plan[cap_pkg::CFG_TICK_RATE]   = $urandom;
        apply_config(8'hff);
        add_random(200);
        wait_idle();

        // catch any stray result after the last one
        repeat (100) @(posedge aclk);
        if (predicted.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, predicted.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
sv/cap_pkg.sv
sv/cap_sequencer.sv
sv/cap_datapath.sv
sv/cascaded_angle_rate_pid.sv
tb/testbench.sv
